// ----- src/rtcb_pkg.sv -----
// Shared types and constants of the RGB text command blinker.
// Used by the line parser and the top level.
// No dependencies.
package rtcb_pkg;

  // Channel commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Characters of the command text
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Drive levels
  localparam logic [7:0] LEVEL_MAX = 8'hff;
  localparam logic [7:0] LEVEL_OFF = 8'h00;

  // Field accumulators
  localparam int unsigned ACC_WIDTH = 24;

  // Field codes; FIELD_DONE means the third field was closed by a NUL byte
  localparam logic [1:0] FIELD_RED   = 2'd0;
  localparam logic [1:0] FIELD_GREEN = 2'd1;
  localparam logic [1:0] FIELD_BLUE  = 2'd2;
  localparam logic [1:0] FIELD_DONE  = 2'd3;

  // Blink period register
  localparam int unsigned   PERIOD_WIDTH = 16;
  localparam logic [15:0]   PERIOD_RESET = 16'd500;
  localparam int unsigned   ADDR_WIDTH   = 3;
  localparam logic          REG_BLINK_PERIOD = 1'b0;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic committed;
    logic dropped;
  } line_status_t;

endpackage

// ----- src/rtcb_if.sv -----
// Valid/ready channel interfaces of the RGB text command blinker.
// Depends on nothing outside this file.
interface rtcb_cmd_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface rtcb_led_if;
  logic       valid;
  logic       ready;
  logic [7:0] led_red;
  logic [7:0] led_green;
  logic [7:0] led_blue;
  logic       lit;
  logic       committed;
  logic       dropped;

  modport source (output valid, output led_red, output led_green, output led_blue,
                  output lit, output committed, output dropped, input ready);
  modport sink   (input valid, input led_red, input led_green, input led_blue,
                  input lit, input committed, input dropped, output ready);
endinterface

// ----- src/rtcb_line_parser.sv -----
// Command line parser: builds three decimal fields and commits the colour.
// Depends on rtcb_pkg.
module rtcb_line_parser #(
  parameter int unsigned LINE_CAPACITY = 29
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  byte_valid_i,
  input  logic [7:0]            byte_i,
  output rtcb_pkg::rgb_t        colour_o,
  output rtcb_pkg::line_status_t status_o
);

  localparam int unsigned LenWidth = $clog2(LINE_CAPACITY + 1);
  localparam int unsigned AccW     = rtcb_pkg::ACC_WIDTH;
  localparam int unsigned WideW    = AccW + 5;
  localparam logic signed [WideW-1:0] AccMax = WideW'((64'sd1 <<< (AccW - 1)) - 1);
  localparam logic signed [WideW-1:0] AccMin = -WideW'(64'sd1 <<< (AccW - 1));

  // Multiply by ten, add the digit value and saturate to the accumulator range.
  function automatic logic signed [AccW-1:0] mac_digit(
    input logic signed [AccW-1:0] acc,
    input logic [7:0]             chr
  );
    logic signed [WideW-1:0] wide;
    logic signed [WideW-1:0] digit;
    logic signed [WideW-1:0] sum;
    wide  = WideW'(acc);
    digit = $signed(WideW'(chr)) - $signed(WideW'(rtcb_pkg::CHAR_ZERO));
    sum   = (wide <<< 3) + (wide <<< 1) + digit;
    if (sum > AccMax) begin
      return AccMax[AccW-1:0];
    end else if (sum < AccMin) begin
      return AccMin[AccW-1:0];
    end
    return sum[AccW-1:0];
  endfunction

  // Clamp an accumulator to a drive level.
  function automatic logic [7:0] clamp_level(input logic signed [AccW-1:0] acc);
    if (acc[AccW-1]) begin
      return rtcb_pkg::LEVEL_OFF;
    end else if (|acc[AccW-2:8]) begin
      return rtcb_pkg::LEVEL_MAX;
    end
    return acc[7:0];
  endfunction

  logic [1:0]                 field_q, field_d;
  logic signed [AccW-1:0]     acc_q [3];
  logic signed [AccW-1:0]     acc_d [3];
  logic [LenWidth-1:0]        len_q, len_d;
  rtcb_pkg::rgb_t             colour_q, colour_d;
  logic signed [AccW-1:0]     acc_sel;
  logic signed [AccW-1:0]     acc_next;
  logic                       is_eol;

  // Accumulator of the open field and its next value
  always_comb begin
    unique case (field_q)
      rtcb_pkg::FIELD_RED:   acc_sel = acc_q[0];
      rtcb_pkg::FIELD_GREEN: acc_sel = acc_q[1];
      default:               acc_sel = acc_q[2];
    endcase
    acc_next = mac_digit(acc_sel, byte_i);
  end

  assign is_eol = (byte_i == rtcb_pkg::CHAR_CR) || (byte_i == rtcb_pkg::CHAR_LF);

  // Per-byte line update
  always_comb begin
    field_d  = field_q;
    acc_d    = acc_q;
    len_d    = len_q;
    colour_d = colour_q;
    status_o = '0;
    if (byte_valid_i) begin
      if (is_eol) begin
        if (len_q != '0) begin
          colour_d.red   = clamp_level(acc_q[0]);
          colour_d.green = clamp_level(acc_q[1]);
          colour_d.blue  = clamp_level(acc_q[2]);
          status_o.committed = 1'b1;
          field_d  = rtcb_pkg::FIELD_RED;
          acc_d[0] = '0;
          acc_d[1] = '0;
          acc_d[2] = '0;
          len_d    = '0;
        end
      end else if (len_q >= LenWidth'(LINE_CAPACITY)) begin
        status_o.dropped = 1'b1;
      end else begin
        len_d = len_q + LenWidth'(1);
        unique case (field_q)
          rtcb_pkg::FIELD_RED, rtcb_pkg::FIELD_GREEN: begin
            if (byte_i == rtcb_pkg::CHAR_SPACE) begin
              field_d = field_q + 2'd1;
            end else begin
              acc_d[field_q] = acc_next;
            end
          end
          rtcb_pkg::FIELD_BLUE: begin
            if (byte_i == rtcb_pkg::CHAR_NUL) begin
              field_d = rtcb_pkg::FIELD_DONE;
            end else begin
              acc_d[2] = acc_next;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q  <= rtcb_pkg::FIELD_RED;
      acc_q[0] <= '0;
      acc_q[1] <= '0;
      acc_q[2] <= '0;
      len_q    <= '0;
      colour_q <= '{red: rtcb_pkg::LEVEL_MAX, green: rtcb_pkg::LEVEL_MAX,
                    blue: rtcb_pkg::LEVEL_MAX};
    end else begin
      field_q  <= field_d;
      acc_q    <= acc_d;
      len_q    <= len_d;
      colour_q <= colour_d;
    end
  end

  assign colour_o = colour_q;

endmodule

// ----- src/rgb_text_command_blinker.sv -----
// Top level of the RGB text command blinker: handshakes, blink timer, register port.
// Depends on rtcb_pkg, rtcb_if.sv and rtcb_line_parser.
//
// Usage: the input channel carries either a text byte (cmd 0) or a one-millisecond
// tick (cmd 1). Bytes form a line "R G B" of decimal fields; CR or LF commits a non-empty
// line as the colour. Ticks run the blink timer, which swaps the drive between the
// colour and off every blink_period ticks. Every input transfer yields exactly one
// result transfer with the drive levels, the blink phase and the committed and
// dropped flags of that item.
// The result of an item is registered in the result buffer. One item is taken per cycle
// while input ready is high; the whole update sits between the input
// handshake and a two-entry result buffer (output register plus skid register).
// When the receiver stalls, the buffer absorbs one more item and then input ready
// drops until the output moves again.
// Reset clears the line, sets the colour and drive to full white with the blink
// phase off and the tick count at zero, and loads blink_period with 500.
// blink_period sits at byte address 0 of the APB port; write it only while idle.
module rgb_text_command_blinker #(
  parameter int unsigned LINE_CAPACITY = 29
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  rtcb_cmd_if.sink                            in_if,
  rtcb_led_if.source                          out_if,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rtcb_pkg::ADDR_WIDTH-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int unsigned PW = rtcb_pkg::PERIOD_WIDTH;

  typedef struct packed {
    rtcb_pkg::rgb_t drive;
    logic           lit;
    logic           committed;
    logic           dropped;
  } result_t;

  logic                   in_xfer;
  logic                   tick;
  logic [PW-1:0]          period_q;
  logic [PW-1:0]          period_eff;
  logic [PW-1:0]          count_q, count_d, count_inc;
  logic                   phase_q, phase_d;
  rtcb_pkg::rgb_t         drive_q, drive_d;
  rtcb_pkg::rgb_t         colour;
  rtcb_pkg::line_status_t line_status;
  result_t                result;
  logic                   out_valid_q, skid_valid_q;
  result_t                out_q, skid_q;
  logic                   reg_sel;

  assign in_xfer     = in_if.valid & in_if.ready;
  assign tick        = in_xfer & (in_if.cmd == rtcb_pkg::CMD_TICK);
  assign in_if.ready = ~skid_valid_q;

  // Line parser
  rtcb_line_parser #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(in_xfer & (in_if.cmd == rtcb_pkg::CMD_BYTE)),
    .byte_i      (in_if.data_byte),
    .colour_o    (colour),
    .status_o    (line_status)
  );

  // Blink timer: a zero period behaves as one
  always_comb begin
    period_eff = (period_q == '0) ? PW'(1) : period_q;
    count_inc  = count_q + PW'(1);
    count_d    = count_q;
    phase_d    = phase_q;
    drive_d    = drive_q;
    if (tick) begin
      count_d = count_inc;
      if (count_inc >= period_eff) begin
        count_d = '0;
        phase_d = ~phase_q;
        drive_d = phase_q ? rtcb_pkg::rgb_t'('0) : colour;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      phase_q <= 1'b0;
      drive_q <= '{red: rtcb_pkg::LEVEL_MAX, green: rtcb_pkg::LEVEL_MAX,
                   blue: rtcb_pkg::LEVEL_MAX};
    end else begin
      count_q <= count_d;
      phase_q <= phase_d;
      drive_q <= drive_d;
    end
  end

  // Result of the item in this cycle
  always_comb begin
    result.drive     = drive_d;
    result.lit       = phase_d;
    result.committed = line_status.committed;
    result.dropped   = line_status.dropped;
  end

  // Result buffer: output register with one skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_if.ready) begin
        out_valid_q  <= skid_valid_q | in_xfer;
        skid_valid_q <= 1'b0;
      end else if (in_xfer) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_if.ready) begin
      out_q <= skid_valid_q ? skid_q : result;
    end
    if (out_valid_q && !out_if.ready && in_xfer) begin
      skid_q <= result;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.led_red   = out_q.drive.red;
  assign out_if.led_green = out_q.drive.green;
  assign out_if.led_blue  = out_q.drive.blue;
  assign out_if.lit       = out_q.lit;
  assign out_if.committed = out_q.committed;
  assign out_if.dropped   = out_q.dropped;

  // Register port: the word index sits above the byte offset
  assign reg_sel = (paddr[rtcb_pkg::ADDR_WIDTH-1] == rtcb_pkg::REG_BLINK_PERIOD);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(32 - PW){1'b0}}, period_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= rtcb_pkg::PERIOD_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      period_q <= pwdata[PW-1:0];
    end
  end

endmodule
